### sv/nlpa_pkg.sv
// Shared types and constants for the length-prefix to Annex B converter.
// No dependencies.
package nlpa_pkg;

  localparam int MaxRes     = 8;  // results one input byte can cause
  localparam int ResCntW    = 4;  // holds 0..MaxRes
  localparam int DelayDepth = 5;  // Annex B start code search window
  localparam int NaluLenW   = 32; // width of the reported NALU length

  typedef enum logic [1:0] {
    CFG_ANNEXB   = 2'd0,
    CFG_LEN_SIZE = 2'd1,
    CFG_PRIV     = 2'd2,
    CFG_AUD      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]          data_b;
    logic                valid;
    logic                splice;
    logic                done;
    logic [NaluLenW-1:0] len;
    logic                err;
    logic                last;
  } res_t;

  function automatic res_t mk_res(logic [7:0] b, logic valid, logic splice, logic err);
    res_t r;
    r        = '0;
    r.data_b = valid ? b : 8'd0;
    r.valid  = valid;
    r.splice = splice;
    r.err    = err;
    return r;
  endfunction

endpackage

### sv/nlpa_front.sv
// Front end: accepts packet bytes, tracks parse state, builds the result list per byte.
// Depends on nlpa_pkg.
module nlpa_front import nlpa_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_key_i,
  input  logic       in_end_i,
  input  logic       cfg_valid_i,
  input  cfg_idx_e   cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       space_ok_i,
  output logic [ResCntW-1:0] push_n_o,
  output res_t       push_res_o [MaxRes]
);

  typedef enum logic [1:0] {PH_PREFIX, PH_FIRST, PH_PAYLOAD, PH_NALU} phase_e;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  logic                   annexb_q, priv_q;
  logic [2:0]             len_size_q;
  logic [7:0]             aud_q;
  phase_e                 phase_q, phase_d;
  logic [2:0]             pc_q, pc_d;
  logic [LENGTH_BITS-1:0] acc_q, acc_d, bl_q, bl_d, cnt_q, cnt_d;
  logic [7:0]             dl_q [DelayDepth];
  logic [7:0]             dl_d [DelayDepth];
  logic                   pend_q, pend_d, err_q, err_d, open_q, open_d;
  res_t                   res [MaxRes];
  logic [ResCntW-1:0]     n;
  logic                   in_fire;

  function automatic logic [LENGTH_BITS-1:0] sat_inc(logic [LENGTH_BITS-1:0] v);
    return (v == LenMax) ? v : v + 1'b1;
  endfunction

  // register writes take the cycle; no byte is taken alongside one
  assign in_ready_o = space_ok_i && !cfg_valid_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push_n_o   = in_fire ? n : '0;
  assign push_res_o = res;

  always_comb begin
    logic [2:0] ls;
    logic       sp;
    logic       go;
    logic [7:0] b;
    phase_d = phase_q;
    pc_d    = pc_q;
    acc_d   = acc_q;
    bl_d    = bl_q;
    cnt_d   = cnt_q;
    dl_d    = dl_q;
    pend_d  = pend_q;
    err_d   = err_q;
    open_d  = open_q;
    n       = '0;
    sp      = 1'b0;
    go      = 1'b1;
    b       = in_byte_i;
    for (int i = 0; i < MaxRes; i++) res[i] = '0;
    ls = len_size_q;
    if (ls < 3'd1) ls = 3'd1;
    if (ls > 3'd4) ls = 3'd4;

    if (!open_q) begin
      open_d = 1'b1;
      pend_d = in_key_i && priv_q;
    end
    if (!err_q) begin
      if (!annexb_q) begin
        if (phase_d == PH_NALU) phase_d = PH_PREFIX;
        if (phase_d == PH_PREFIX) begin
          if (|acc_d[LENGTH_BITS-1 -: 8]) acc_d = LenMax;
          else acc_d = {acc_d[LENGTH_BITS-9:0], b};
          pc_d = pc_d + 3'd1;
          if (pc_d < ls) begin
            if (in_end_i) begin
              if (pend_d) begin res[n[2:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0); n = n + 1'b1; end
              pend_d = 1'b0;
            end
          end else begin
            pc_d  = '0;
            bl_d  = acc_d;
            acc_d = '0;
            cnt_d = '0;
            if (bl_d == '0) begin
              sp = pend_d;
              if (sp) pend_d = 1'b0;
              for (int k = 0; k < 4; k++) begin
                res[n[2:0]] = mk_res((k == 3) ? 8'd1 : 8'd0, 1'b1, (k == 0) && sp, 1'b0);
                n = n + 1'b1;
                cnt_d = sat_inc(cnt_d);
              end
              res[3'(n - 1'b1)].done = 1'b1;
              res[3'(n - 1'b1)].len  = NaluLenW'(cnt_d);
              if (in_end_i) begin
                if (pend_d) begin res[n[2:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0); n = n + 1'b1; end
                pend_d = 1'b0;
              end
            end else if (in_end_i) begin
              res[n[2:0]] = mk_res(8'd0, 1'b0, 1'b0, 1'b1); n = n + 1'b1;
              pend_d = 1'b0;
              err_d  = 1'b1;
            end else begin
              phase_d = PH_FIRST;
            end
          end
        end else begin
          if (phase_d == PH_FIRST) begin
            cnt_d = '0;
            sp = pend_d && (b != aud_q);
            if (sp) pend_d = 1'b0;
            for (int k = 0; k < 4; k++) begin
              res[n[2:0]] = mk_res((k == 3) ? 8'd1 : 8'd0, 1'b1, (k == 0) && sp, 1'b0);
              n = n + 1'b1;
              cnt_d = sat_inc(cnt_d);
            end
          end
          res[n[2:0]] = mk_res(b, 1'b1, 1'b0, 1'b0); n = n + 1'b1;
          cnt_d = sat_inc(cnt_d);
          phase_d = PH_PAYLOAD;
          if (bl_d != '0) bl_d = bl_d - 1'b1;
          if (bl_d == '0) begin
            res[3'(n - 1'b1)].done = 1'b1;
            res[3'(n - 1'b1)].len  = NaluLenW'(cnt_d);
            phase_d = PH_PREFIX;
            if (in_end_i) begin
              if (pend_d) begin res[n[2:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0); n = n + 1'b1; end
              pend_d = 1'b0;
            end
          end else if (in_end_i) begin
            res[n[2:0]] = mk_res(8'd0, 1'b0, 1'b0, 1'b1); n = n + 1'b1;
            pend_d = 1'b0;
            err_d  = 1'b1;
          end
        end
      end else begin
        for (int k = 0; k < DelayDepth - 1; k++) dl_d[k] = dl_q[k+1];
        dl_d[DelayDepth-1] = b;
        if (phase_d != PH_NALU) begin
          phase_d = PH_PREFIX;
          pc_d = pc_d + 3'd1;
          if (pc_d < 3'd4) begin
            go = 1'b0;
            if (in_end_i) begin
              if (pend_d) begin res[n[2:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0); n = n + 1'b1; end
              pend_d = 1'b0;
            end
          end else if (pc_d == 3'd4) begin
            go = 1'b0;
            if (!(dl_d[1] == 8'd0 && dl_d[2] == 8'd0 && dl_d[3] == 8'd0 && dl_d[4] == 8'd1)) begin
              res[n[2:0]] = mk_res(8'd0, 1'b0, 1'b0, 1'b1); n = n + 1'b1;
              pend_d = 1'b0;
              err_d  = 1'b1;
            end else if (in_end_i) begin
              cnt_d = '0;
              sp = pend_d;
              if (sp) pend_d = 1'b0;
              for (int k = 0; k < 4; k++) begin
                res[n[2:0]] = mk_res((k == 3) ? 8'd1 : 8'd0, 1'b1, (k == 0) && sp, 1'b0);
                n = n + 1'b1;
                cnt_d = sat_inc(cnt_d);
              end
              res[3'(n - 1'b1)].done = 1'b1;
              res[3'(n - 1'b1)].len  = NaluLenW'(cnt_d);
            end
          end else begin
            cnt_d = '0;
            sp = pend_d && (b != aud_q);
            if (sp) pend_d = 1'b0;
            res[n[2:0]] = mk_res(dl_d[0], 1'b1, sp, 1'b0); n = n + 1'b1;
            cnt_d = sat_inc(cnt_d);
            phase_d = PH_NALU;
            pc_d = 3'd4;
          end
        end else if (dl_d[0] == 8'd0 && dl_d[1] == 8'd0 && dl_d[2] == 8'd0 && dl_d[3] == 8'd1) begin
          // next start code at the head of the window closes the open NALU
          res[n[2:0]]      = mk_res(8'd0, 1'b0, 1'b0, 1'b0);
          res[n[2:0]].done = 1'b1;
          res[n[2:0]].len  = NaluLenW'(cnt_d);
          n = n + 1'b1;
          cnt_d = '0;
          sp = pend_d && (b != aud_q);
          if (sp) pend_d = 1'b0;
          res[n[2:0]] = mk_res(dl_d[0], 1'b1, sp, 1'b0); n = n + 1'b1;
          cnt_d = sat_inc(cnt_d);
        end else begin
          res[n[2:0]] = mk_res(dl_d[0], 1'b1, 1'b0, 1'b0); n = n + 1'b1;
          cnt_d = sat_inc(cnt_d);
        end
        if (go && in_end_i) begin
          // flush the window
          for (int k = 1; k < DelayDepth; k++) begin
            res[n[2:0]] = mk_res(dl_d[k], 1'b1, 1'b0, 1'b0); n = n + 1'b1;
            cnt_d = sat_inc(cnt_d);
          end
          res[3'(n - 1'b1)].done = 1'b1;
          res[3'(n - 1'b1)].len  = NaluLenW'(cnt_d);
          if (pend_d) begin res[n[2:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0); n = n + 1'b1; end
          pend_d = 1'b0;
        end
      end
    end
    if (in_end_i) begin
      phase_d = PH_PREFIX;
      pc_d    = '0;
      acc_d   = '0;
      bl_d    = '0;
      cnt_d   = '0;
      for (int k = 0; k < DelayDepth; k++) dl_d[k] = 8'd0;
      pend_d  = 1'b0;
      err_d   = 1'b0;
      open_d  = 1'b0;
    end
    if (n != '0) res[3'(n - 1'b1)].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      annexb_q   <= 1'b0;
      len_size_q <= 3'd4;
      priv_q     <= 1'b0;
      aud_q      <= 8'd9;
      phase_q    <= PH_PREFIX;
      pc_q       <= '0;
      acc_q      <= '0;
      bl_q       <= '0;
      cnt_q      <= '0;
      for (int k = 0; k < DelayDepth; k++) dl_q[k] <= 8'd0;
      pend_q     <= 1'b0;
      err_q      <= 1'b0;
      open_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ANNEXB:   annexb_q   <= cfg_data_i[0];
        CFG_LEN_SIZE: len_size_q <= cfg_data_i[2:0];
        CFG_PRIV:     priv_q     <= cfg_data_i[0];
        CFG_AUD:      aud_q      <= cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i == CFG_ANNEXB || cfg_index_i == CFG_LEN_SIZE) begin
        // mode change restarts parsing
        phase_q <= PH_PREFIX;
        pc_q    <= '0;
        acc_q   <= '0;
        bl_q    <= '0;
        cnt_q   <= '0;
        for (int k = 0; k < DelayDepth; k++) dl_q[k] <= 8'd0;
        pend_q  <= 1'b0;
        err_q   <= 1'b0;
        open_q  <= 1'b0;
      end
    end else if (in_fire) begin
      phase_q <= phase_d;
      pc_q    <= pc_d;
      acc_q   <= acc_d;
      bl_q    <= bl_d;
      cnt_q   <= cnt_d;
      dl_q    <= dl_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
      open_q  <= open_d;
    end
  end

endmodule

### sv/nlpa_queue.sv
// Result queue between front end and output: takes up to MaxRes results per cycle,
// hands out one per cycle while out_ready_i is high. Depends on nlpa_pkg.
module nlpa_queue import nlpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ResCntW-1:0] push_n_i,
  input  res_t               push_res_i [MaxRes],
  output logic               space_ok_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output res_t               out_res_o
);

  localparam int Depth = 2 * MaxRes;
  localparam int PtrW  = $clog2(Depth);

  res_t              mem_q [Depth];
  logic [PtrW-1:0]   head_q, tail_q;
  logic [PtrW:0]     count_q;
  logic              pop;

  assign space_ok_o  = count_q <= (PtrW+1)'(Depth - MaxRes);
  assign out_valid_o = count_q != '0;
  assign out_res_o   = mem_q[head_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (ResCntW'(i) < push_n_i) mem_q[PtrW'(tail_q + PtrW'(i))] <= push_res_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_q + PtrW'(push_n_i);
      if (pop) head_q <= head_q + 1'b1;
      count_q <= count_q + (PtrW+1)'(push_n_i) - (PtrW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth)) else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != '0) |-> space_ok_o) else $error("push without room");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(head_q)))
    else $error("stalled result lost");

endmodule

### sv/nalu_length_prefix_to_annexb_unit.sv
// Top level of the length-prefix / Annex B NALU converter.
// An accepted byte's results are registered in the 16-entry result queue; a start code
// adds up to four of them. Throughput: one input byte per cycle while the queue has room
// and no cfg write is pending; results drain one per cycle while m_axis_tready is set.
// Reset: asynchronous, clears parse state and restores register defaults.
// Depends on nlpa_pkg, nlpa_front, nlpa_queue.
module nalu_length_prefix_to_annexb_unit import nlpa_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] key_frame
  input  logic        s_axis_tlast,   // packet_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] nalu_length
  output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [1] splice_here, [2] nalu_done,
                                      // [3] format_error
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic               space_ok;
  logic [ResCntW-1:0] push_n;
  res_t               push_res [MaxRes];
  res_t               out_res;

  assign cfg_ready_o = 1'b1;

  nlpa_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_key_i    (s_axis_tuser),
    .in_end_i    (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .space_ok_i  (space_ok),
    .push_n_o    (push_n),
    .push_res_o  (push_res)
  );

  nlpa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_res_i  (push_res),
    .space_ok_o  (space_ok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.len, out_res.data_b};
  assign m_axis_tuser = {out_res.err, out_res.done, out_res.splice, out_res.valid};
  assign m_axis_tlast = out_res.last;

endmodule
